// ===== sv/iwrt_pkg.sv =====
// ----------------------------------------------------------------------------
// iwrt_pkg
// Types and constants shared by the window tracker and reorder buffer.
// ----------------------------------------------------------------------------
package iwrt_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_W     = 6;
    localparam int MEM_W      = 9;   // mark bit over an 8-bit retry count
    localparam int DIV_W      = 40;  // growth gain shifted up by 32 bits
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_WINDOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 3'd4;

    localparam logic [1:0] FUNC_SEND    = 2'd0;
    localparam logic [1:0] FUNC_DATA    = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

    localparam logic [6:0] NO_FINAL_SLOT = 7'h7F;

    typedef enum logic [2:0] {
        ST_ISSUED    = 3'd0,
        ST_BUFFERED  = 3'd1,
        ST_DELIVERED = 3'd2,
        ST_OUTWIN    = 3'd3,
        ST_IGNORED   = 3'd4,
        ST_RETX      = 3'd5,
        ST_FAILED    = 3'd6,
        ST_NOTSENT   = 3'd7
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_DIV,
        S_MUL,
        S_SHR,
        S_DR_RD,
        S_DR_EVAL,
        S_EMIT,
        S_DR_STEP
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [MEM_W-1:0]  wr_data;
    } t_mem_req;

endpackage

// ===== sv/iwrt_mem.sv =====
// ----------------------------------------------------------------------------
// iwrt_mem
// Slot memory holding the received mark and retry count of each slot, with
// one valid bit per entry so that unwritten entries read as cleared.
// ----------------------------------------------------------------------------
module iwrt_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  iwrt_pkg::t_mem_req         i_req,
    output logic [iwrt_pkg::MEM_W-1:0] o_data
);

    logic [iwrt_pkg::MEM_W-1:0] r_mem [iwrt_pkg::SLOTS];
    logic [iwrt_pkg::SLOTS-1:0] r_vld;
    logic [iwrt_pkg::MEM_W-1:0] r_q;
    logic                       r_qv;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_qv <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_data = r_qv ? r_q : '0;

endmodule

// ===== sv/iwrt_div.sv =====
// ----------------------------------------------------------------------------
// iwrt_div
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iwrt_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [iwrt_pkg::DIV_W-1:0] i_dividend,
    input  logic [31:0]                i_divisor,
    output logic                       o_busy,
    output logic [iwrt_pkg::DIV_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(iwrt_pkg::DIV_W + 1);

    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic [iwrt_pkg::DIV_W-1:0] r_quot;
    logic [31:0]               r_rem;
    logic [31:0]               r_div;
    logic [32:0]               rem_sh;
    logic [32:0]               rem_sub;
    logic                      ge;

    always_comb begin
        rem_sh  = {r_rem, r_quot[iwrt_pkg::DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        ge      = rem_sh >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(iwrt_pkg::DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[iwrt_pkg::DIV_W-2:0], ge};
            r_rem  <= ge ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// ===== sv/interest_window_reorder_tracker_core.sv =====
// ----------------------------------------------------------------------------
// interest_window_reorder_tracker_core
// Window tracker and reorder buffer for the receiver of a request protocol.
// ----------------------------------------------------------------------------
// The input channel carries one request per event: a send request, a data
// arrival or a timeout. The output channel returns one or more results per
// request; the final one has o_last set. A request is taken only while the
// block is idle, and one request is worked on at a time.
// A data arrival that grows the window runs the 40-step divider for gain
// over window. Each further slot drained from the reorder buffer passes
// through the write-back of the slot, a read of the next slot in the slot
// memory, its decision and the hand-over to the output register.
// Results sit in an output register, so a stalled receiver holds the current
// result and the block waits before placing the next one. After a
// synchronous reset the window equals the floor, all slots read as empty and
// the configuration registers take their default values. Configuration must
// be written by the user only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module interest_window_reorder_tracker_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [iwrt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [iwrt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_func,
    input  logic [31:0]                    i_seq,
    input  logic                           i_final_valid,
    input  logic [31:0]                    i_final_block,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_status,
    output logic [31:0]                    o_out_seq,
    output logic [5:0]                     o_slot_index,
    output logic [31:0]                    o_window_q16,
    output logic                           o_download_done,
    output logic                           o_last
);

    localparam int SW = iwrt_pkg::SLOT_W;

    // configuration
    logic [15:0] r_max_window, r_floor, r_shrink;
    logic [7:0]  r_gain, r_retry_limit;

    // control state
    iwrt_pkg::t_state r_state, n_state;
    logic [1:0]  r_func;
    logic [31:0] r_seq, r_fblock;
    logic        r_fvalid;
    logic [31:0] r_next_seq, n_next_seq;
    logic [SW-1:0] r_head, n_head;
    logic [31:0] r_fchunk, n_fchunk;
    logic [6:0]  r_fslot, n_fslot;
    logic [15:0] r_pend, n_pend;
    logic [6:0]  r_buf, n_buf;
    logic [31:0] r_window, n_window;
    logic [SW-1:0] r_h, n_h;
    logic [SW-1:0] r_guard, n_guard;
    logic        r_drain, n_drain;
    logic [47:0] r_prod;

    // staged result
    iwrt_pkg::t_status r_stg_status, n_stg_status;
    logic [31:0] r_stg_seq, n_stg_seq;
    logic [SW-1:0] r_stg_slot, n_stg_slot;
    logic        r_stg_done, n_stg_done, r_stg_last, n_stg_last;

    // output register
    logic        r_out_valid, n_out_valid;
    iwrt_pkg::t_status r_out_status;
    logic [31:0] r_out_seq, r_out_window;
    logic [SW-1:0] r_out_slot;
    logic        r_out_done, r_out_last;
    logic        out_free, push;

    iwrt_pkg::t_mem_req mem_req;
    logic [iwrt_pkg::MEM_W-1:0] mem_q;
    logic        m_mark;
    logic [7:0]  m_retry;

    logic        div_start, div_busy;
    logic [iwrt_pkg::DIV_W-1:0] div_quot;
    logic [40:0] grow_sum;

    // decode of the request in S_EVAL
    logic [SW-1:0] slot, nslot, h1;
    logic [31:0] fc_new;
    logic [6:0]  fs_new;
    logic [6:0]  buf_head;
    logic        can_issue, outside, at_head, accept_d, grow, retx, drain;
    logic [6:0]  dr_buf;
    logic [SW-1:0] dr_h1, dr_guard1;

    iwrt_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_data  (mem_q)
    );

    iwrt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_gain, 32'h0}),
        .i_divisor  (r_window),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign m_mark   = mem_q[8];
    assign m_retry  = mem_q[7:0];
    assign out_free = !r_out_valid || !i_out_stall;
    assign push     = (r_state == iwrt_pkg::S_EMIT) && out_free;
    assign grow_sum = {9'h0, r_window} + {1'b0, div_quot};

    always_comb begin
        slot      = r_seq[SW-1:0];
        nslot     = r_next_seq[SW-1:0];
        h1        = slot + 1'b1;
        can_issue = (r_pend < r_window[31:16]) && (r_next_seq < r_fchunk);
        fc_new    = (r_fvalid && (r_fblock < r_fchunk)) ? r_fblock + 32'd1 : r_fchunk;
        outside   = ((nslot > r_head) && ((slot > nslot) || (slot < r_head)))
                 || ((nslot < r_head) && (slot > nslot) && (slot < r_head));
        fs_new    = (r_seq == fc_new - 32'd1) ? {1'b0, slot} : r_fslot;
        at_head   = (slot == r_head);
        buf_head  = (m_mark && (r_buf != 7'd0)) ? r_buf - 7'd1 : r_buf;
        accept_d  = (r_func == iwrt_pkg::FUNC_DATA) && !outside
                 && (at_head || !m_mark);
        grow      = accept_d && (r_window[31:16] < r_max_window);
        retx      = (r_func == iwrt_pkg::FUNC_TIMEOUT) && !(r_seq >= r_fchunk || m_mark)
                 && !((r_retry_limit != 8'd0) && (m_retry >= r_retry_limit));
        drain     = (r_func == iwrt_pkg::FUNC_DATA) && !outside && at_head
                 && !(({1'b0, h1} >= fs_new) && (buf_head == 7'd0))
                 && (buf_head != 7'd0);
        dr_buf    = r_buf - 7'd1;
        dr_h1     = r_h + 1'b1;
        dr_guard1 = r_guard + 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            iwrt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = iwrt_pkg::S_RD;
                end
            end
            iwrt_pkg::S_RD: n_state = iwrt_pkg::S_EVAL;
            iwrt_pkg::S_EVAL: begin
                if (retx) begin
                    n_state = iwrt_pkg::S_MUL;
                end else if (grow && (r_window != 32'h0)) begin
                    n_state = iwrt_pkg::S_DIV;
                end else if (drain) begin
                    n_state = iwrt_pkg::S_DR_RD;
                end else begin
                    n_state = iwrt_pkg::S_EMIT;
                end
            end
            iwrt_pkg::S_DIV: begin
                if (!div_busy) begin
                    n_state = r_drain ? iwrt_pkg::S_DR_RD : iwrt_pkg::S_EMIT;
                end
            end
            iwrt_pkg::S_MUL:     n_state = iwrt_pkg::S_SHR;
            iwrt_pkg::S_SHR:     n_state = iwrt_pkg::S_EMIT;
            iwrt_pkg::S_DR_RD:   n_state = iwrt_pkg::S_DR_EVAL;
            iwrt_pkg::S_DR_EVAL: n_state = iwrt_pkg::S_EMIT;
            iwrt_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = r_stg_last ? iwrt_pkg::S_IDLE : iwrt_pkg::S_DR_STEP;
                end
            end
            iwrt_pkg::S_DR_STEP: begin
                if (({1'b0, r_h} < r_fslot) && (dr_guard1 < SW'(iwrt_pkg::SLOTS - 1))
                        && (dr_buf != 7'd0)) begin
                    n_state = iwrt_pkg::S_DR_RD;
                end else begin
                    n_state = iwrt_pkg::S_EMIT;
                end
            end
            default: n_state = iwrt_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_next_seq   = r_next_seq;
        n_head       = r_head;
        n_fchunk     = r_fchunk;
        n_fslot      = r_fslot;
        n_pend       = r_pend;
        n_buf        = r_buf;
        n_window     = r_window;
        n_h          = r_h;
        n_guard      = r_guard;
        n_drain      = r_drain;
        n_stg_status = r_stg_status;
        n_stg_seq    = r_stg_seq;
        n_stg_slot   = r_stg_slot;
        n_stg_done   = r_stg_done;
        n_stg_last   = r_stg_last;
        mem_req      = '0;
        div_start    = 1'b0;
        o_in_stall   = (r_state != iwrt_pkg::S_IDLE);

        case (r_state)
            iwrt_pkg::S_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = (r_func == iwrt_pkg::FUNC_SEND) ? nslot : slot;
            end
            iwrt_pkg::S_EVAL: begin
                n_stg_seq  = 32'h0;
                n_stg_slot = slot;
                n_stg_done = 1'b0;
                n_stg_last = !drain;
                n_drain    = drain;
                if (accept_d) begin
                    n_pend = (r_pend != 16'h0) ? r_pend - 16'd1 : r_pend;
                    if (grow && (r_window == 32'h0)) begin
                        n_window = 32'hFFFF_FFFF;
                    end
                    div_start = grow && (r_window != 32'h0);
                end
                case (r_func)
                    iwrt_pkg::FUNC_SEND: begin
                        if (can_issue) begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = nslot;
                            mem_req.wr_data = '0;
                            n_buf        = buf_head;
                            n_stg_status = iwrt_pkg::ST_ISSUED;
                            n_stg_seq    = r_next_seq;
                            n_stg_slot   = nslot;
                            n_next_seq   = r_next_seq + 32'd1;
                            n_pend       = (r_pend != 16'hFFFF) ? r_pend + 16'd1 : r_pend;
                        end else begin
                            n_stg_status = iwrt_pkg::ST_NOTSENT;
                            n_stg_slot   = '0;
                        end
                    end
                    iwrt_pkg::FUNC_DATA: begin
                        n_fchunk = fc_new;
                        if (outside) begin
                            n_stg_status = iwrt_pkg::ST_OUTWIN;
                        end else begin
                            n_fslot = fs_new;
                            if (!at_head) begin
                                if (!m_mark) begin
                                    mem_req.wr_en   = 1'b1;
                                    mem_req.wr_addr = slot;
                                    mem_req.wr_data = {1'b1, m_retry};
                                    n_buf        = r_buf + 7'd1;
                                    n_stg_status = iwrt_pkg::ST_BUFFERED;
                                end else begin
                                    n_stg_status = iwrt_pkg::ST_IGNORED;
                                end
                            end else begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = slot;
                                mem_req.wr_data = {1'b0, m_retry};
                                n_buf        = buf_head;
                                n_stg_status = iwrt_pkg::ST_DELIVERED;
                                n_head       = h1;
                                n_h          = h1;
                                n_guard      = '0;
                                if (({1'b0, h1} >= fs_new) && (buf_head == 7'd0)) begin
                                    n_pend     = 16'h0;
                                    n_stg_done = 1'b1;
                                end
                            end
                        end
                    end
                    iwrt_pkg::FUNC_TIMEOUT: begin
                        if ((r_seq >= r_fchunk) || m_mark) begin
                            n_stg_status = iwrt_pkg::ST_IGNORED;
                        end else if (!retx) begin
                            n_stg_status = iwrt_pkg::ST_FAILED;
                        end else begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = slot;
                            mem_req.wr_data = {1'b0, (m_retry != 8'hFF) ? m_retry + 8'd1
                                                                        : m_retry};
                            n_stg_status = iwrt_pkg::ST_RETX;
                            n_stg_seq    = r_seq;
                        end
                    end
                    default: begin
                        n_stg_status = iwrt_pkg::ST_IGNORED;
                        n_stg_slot   = '0;
                    end
                endcase
            end
            iwrt_pkg::S_DIV: begin
                if (!div_busy) begin
                    n_window = (grow_sum[40:32] != 9'h0) ? 32'hFFFF_FFFF : grow_sum[31:0];
                end
            end
            iwrt_pkg::S_SHR: begin
                n_window = (r_prod[47:16] < {r_floor, 16'h0}) ? {r_floor, 16'h0}
                                                              : r_prod[47:16];
            end
            iwrt_pkg::S_DR_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_h;
            end
            iwrt_pkg::S_DR_EVAL: begin
                // the staged result is the last one unless the next slot holds data
                n_stg_last = !m_mark;
            end
            iwrt_pkg::S_DR_STEP: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_h;
                mem_req.wr_data = {1'b0, m_retry};
                n_buf        = dr_buf;
                n_stg_status = iwrt_pkg::ST_DELIVERED;
                n_stg_seq    = 32'h0;
                n_stg_slot   = r_h;
                n_stg_done   = 1'b0;
                n_stg_last   = 1'b1;
                if ({1'b0, r_h} >= r_fslot) begin
                    n_pend     = 16'h0;
                    n_head     = dr_h1;
                    n_stg_done = (dr_buf == 7'd0);
                end else begin
                    n_head  = dr_h1;
                    n_h     = dr_h1;
                    n_guard = dr_guard1;
                    if ((dr_guard1 < SW'(iwrt_pkg::SLOTS - 1)) && (dr_buf != 7'd0)) begin
                        n_stg_last = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        if (push) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_window  <= 16'd64;
            r_gain        <= 8'd1;
            r_shrink      <= 16'd32768;
            r_floor       <= 16'd1;
            r_retry_limit <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                iwrt_pkg::CFG_MAX_WINDOW:   r_max_window  <= i_cfg_data;
                iwrt_pkg::CFG_GROWTH_GAIN:  r_gain        <= i_cfg_data[7:0];
                iwrt_pkg::CFG_SHRINK:       r_shrink      <= i_cfg_data;
                iwrt_pkg::CFG_FLOOR_WINDOW: r_floor       <= i_cfg_data;
                iwrt_pkg::CFG_RETRY_LIMIT:  r_retry_limit <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iwrt_pkg::S_IDLE;
            r_next_seq  <= 32'h0;
            r_head      <= '0;
            r_fchunk    <= 32'hFFFF_FFFF;
            r_fslot     <= iwrt_pkg::NO_FINAL_SLOT;
            r_pend      <= 16'h0;
            r_buf       <= 7'd0;
            r_window    <= 32'h0001_0000;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_seq  <= n_next_seq;
            r_head      <= n_head;
            r_fchunk    <= n_fchunk;
            r_fslot     <= n_fslot;
            r_pend      <= n_pend;
            r_buf       <= n_buf;
            r_window    <= n_window;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == iwrt_pkg::S_IDLE) && i_in_valid) begin
            r_func   <= i_func;
            r_seq    <= i_seq;
            r_fvalid <= i_final_valid;
            r_fblock <= i_final_block;
        end
        if (r_state == iwrt_pkg::S_MUL) begin
            r_prod <= r_window * r_shrink;
        end
        r_h          <= n_h;
        r_guard      <= n_guard;
        r_stg_status <= n_stg_status;
        r_stg_seq    <= n_stg_seq;
        r_stg_slot   <= n_stg_slot;
        r_stg_done   <= n_stg_done;
        r_stg_last   <= n_stg_last;
        if (push) begin
            r_out_status <= r_stg_status;
            r_out_seq    <= r_stg_seq;
            r_out_slot   <= r_stg_slot;
            r_out_window <= r_window;
            r_out_done   <= r_stg_last && r_stg_done;
            r_out_last   <= r_stg_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_out_seq       = r_out_seq;
    assign o_slot_index    = r_out_slot;
    assign o_window_q16    = r_out_window;
    assign o_download_done = r_out_done;
    assign o_last          = r_out_last;

    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf <= 7'(iwrt_pkg::SLOTS))
        else $error("reorder buffer count exceeds the slot count");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == iwrt_pkg::S_EMIT && r_state == iwrt_pkg::S_IDLE)
            |-> (o_out_valid && o_last))
        else $error("returned to idle without presenting the last result");

    a_shrink_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iwrt_pkg::S_SHR) |=> (r_window >= {$past(r_floor), 16'h0}))
        else $error("window decreased below the floor");

    a_drain_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iwrt_pkg::S_DR_RD) |-> (r_guard < SW'(iwrt_pkg::SLOTS - 1)))
        else $error("drain ran past the slot count");

endmodule
